// File: hdl/assert_macros.svh
// Assertion macros used by the controller of the Life generation engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/lge_pkg.sv
// Package with the shared constants, types and cell rule of the Life generation engine.
package lge_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int ACTION_W = 3;
  localparam int ROW_W    = 6;
  localparam int COL_W    = 6;
  localparam int SIZE_W   = 7;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 8;

  localparam int ACT_LSB = 0;
  localparam int ROW_LSB = ACT_LSB + ACTION_W;
  localparam int COL_LSB = ROW_LSB + ROW_W;
  localparam int VAL_LSB = COL_LSB + COL_W;

  localparam logic [ACTION_W-1:0] ACT_WRITE   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_TOGGLE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ    = 3'd4;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  localparam logic [SIZE_W-1:0] ROWS_RESET = 7'd50;
  localparam logic [SIZE_W-1:0] COLS_RESET = 7'd50;

  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd4;

  typedef struct packed {
    logic load;
    logic cell_rd;
    logic cell_wb;
    logic clr_wr;
    logic init_wr;
    logic adv_rd;
    logic adv_wr;
    logic flip;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic in_cell;
    logic in_clear;
    logic in_advance;
    logic can_push;
  } sts_t;

  // Next state of the centre cell of a 3x3 block, given as three 3-bit row slices.
  function automatic logic life_cell(logic [2:0] above, logic [2:0] mid, logic [2:0] below);
    logic [3:0] count;
    count = {3'b0, above[0]} + {3'b0, above[1]} + {3'b0, above[2]}
          + {3'b0, mid[0]} + {3'b0, mid[1]} + {3'b0, mid[2]}
          + {3'b0, below[0]} + {3'b0, below[1]} + {3'b0, below[2]};
    return (count == BIRTH_COUNT) || (mid[1] && (count == STAY_COUNT));
  endfunction

endpackage

// File: hdl/lge_datapath.sv
// Datapath of the Life generation engine: grid memory, row window, size registers and output register.
module lge_datapath import lge_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int AW = RW + 1,
  localparam int CW = $clog2(MAX_ROWS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic [IN_W-1:0]   s_tdata,
  input  logic              m_tready,
  output logic              m_tvalid,
  output logic [OUT_W-1:0]  m_tdata,
  input  cmd_t              cmd,
  input  logic [RW-1:0]     cnt_row,
  input  logic [AW-1:0]     init_addr,
  input  logic [CW-1:0]     adv_tag,
  output sts_t              sts
);

  localparam int DEPTH = 2 << RW;
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int NCW   = $clog2(MAX_COLS + 1);

  logic [SIZE_W-1:0]   rows_cfg;
  logic [SIZE_W-1:0]   cols_cfg;
  logic [CW-1:0]       nr;
  logic [NCW-1:0]      nc;
  logic [MAX_COLS-1:0] colmask;

  logic [ACTION_W-1:0] act_q;
  logic [ROW_W-1:0]    row_q;
  logic [COL_W-1:0]    col_q;
  logic                val_q;
  logic                bank;
  logic                res;
  logic                out_bit;
  logic                out_valid;

  logic [MAX_COLS-1:0] mem [DEPTH];
  logic [MAX_COLS-1:0] rd_data;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [MAX_COLS-1:0] wr_data;

  logic [MAX_COLS-1:0] win_p;
  logic [MAX_COLS-1:0] win_c;
  logic [MAX_COLS-1:0] win_n;
  logic [MAX_COLS+1:0] pad_p;
  logic [MAX_COLS+1:0] pad_c;
  logic [MAX_COLS+1:0] pad_n;
  logic [MAX_COLS-1:0] life_row;
  logic                row_ok;

  logic [CIW-1:0]      col_idx;
  logic                in_grid;
  logic                is_write;
  logic                is_toggle;
  logic [MAX_COLS-1:0] cell_mask;
  logic [MAX_COLS-1:0] cell_word;
  logic [ACTION_W-1:0] in_act;

  assign nr = (int'(rows_cfg) > MAX_ROWS) ? CW'(MAX_ROWS) : CW'(rows_cfg);
  assign nc = (int'(cols_cfg) > MAX_COLS) ? NCW'(MAX_COLS) : NCW'(cols_cfg);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = (c < int'(nc));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= ROWS_RESET;
      cols_cfg <= COLS_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_ROWS) begin
        rows_cfg <= cfg_data;
      end else begin
        cols_cfg <= cfg_data;
      end
    end
  end

  assign in_act         = s_tdata[ACT_LSB +: ACTION_W];
  assign sts.in_cell    = (in_act == ACT_WRITE) || (in_act == ACT_TOGGLE) || (in_act == ACT_READ);
  assign sts.in_clear   = (in_act == ACT_CLEAR);
  assign sts.in_advance = (in_act == ACT_ADVANCE);
  assign sts.can_push   = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= in_act;
      row_q <= s_tdata[ROW_LSB +: ROW_W];
      col_q <= s_tdata[COL_LSB +: COL_W];
      val_q <= s_tdata[VAL_LSB];
    end
  end

  assign col_idx   = CIW'(col_q);
  assign in_grid   = (int'(row_q) < int'(nr)) && (int'(col_q) < int'(nc));
  assign is_write  = (act_q == ACT_WRITE);
  assign is_toggle = (act_q == ACT_TOGGLE);
  assign cell_mask = MAX_COLS'(1) << col_idx;

  always_comb begin
    if (is_write) begin
      cell_word = val_q ? (rd_data | cell_mask) : (rd_data & ~cell_mask);
    end else if (is_toggle) begin
      cell_word = rd_data ^ cell_mask;
    end else begin
      cell_word = rd_data;
    end
  end

  // The incoming row is cut to the active region before it joins the window.
  assign win_n  = (int'(adv_tag) < int'(nr)) ? (rd_data & colmask) : '0;
  assign pad_p  = {1'b0, win_p, 1'b0};
  assign pad_c  = {1'b0, win_c, 1'b0};
  assign pad_n  = {1'b0, win_n, 1'b0};
  assign row_ok = int'(adv_tag) <= int'(nr);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      life_row[c] = life_cell(pad_p[c +: 3], pad_c[c +: 3], pad_n[c +: 3]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      win_p <= '0;
      win_c <= '0;
    end else if (cmd.adv_wr) begin
      win_p <= win_c;
      win_c <= win_n;
    end
  end

  always_comb begin
    rd_en   = cmd.cell_rd || cmd.adv_rd;
    rd_addr = cmd.cell_rd ? {bank, RW'(row_q)} : {bank, cnt_row};
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = init_addr;
    wr_data = '0;
    priority if (cmd.init_wr) begin
      wr_en   = 1'b1;
    end else if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = {bank, cnt_row};
    end else if (cmd.cell_wb) begin
      wr_en   = in_grid && (is_write || is_toggle);
      wr_addr = {bank, RW'(row_q)};
      wr_data = cell_word;
    end else if (cmd.adv_wr) begin
      wr_en   = (adv_tag != '0);
      wr_addr = {~bank, RW'(adv_tag - 1'b1)};
      wr_data = row_ok ? (life_row & colmask) : '0;
    end else begin
      wr_en   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank <= 1'b0;
    end else if (cmd.flip) begin
      bank <= ~bank;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res <= 1'b0;
    end else if (cmd.cell_wb) begin
      res <= in_grid ? cell_word[col_idx] : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_bit <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W - 1)'(0), out_bit};

endmodule

// File: hdl/lge_controller.sv
// Controller state machine of the Life generation engine.
`include "assert_macros.svh"
module lge_controller import lge_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  localparam int RW = $clog2(MAX_ROWS),
  localparam int AW = RW + 1,
  localparam int CW = $clog2(MAX_ROWS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  sts_t          sts,
  output cmd_t          cmd,
  output logic [RW-1:0] cnt_row,
  output logic [AW-1:0] init_addr,
  output logic [CW-1:0] adv_tag
);

  typedef enum logic [7:0] {
    S_INIT    = 8'b0000_0001,
    S_IDLE    = 8'b0000_0010,
    S_CELL    = 8'b0000_0100,
    S_CELL_WB = 8'b0000_1000,
    S_CLR     = 8'b0001_0000,
    S_ADV     = 8'b0010_0000,
    S_ADV_END = 8'b0100_0000,
    S_FIN     = 8'b1000_0000
  } state_t;

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] cnt;
  logic [AW-1:0] init_cnt;
  logic          adv_v;
  logic [CW-1:0] rk;

  assign s_tready  = (state == S_IDLE);
  assign cnt_row   = RW'(cnt);
  assign init_addr = init_cnt;
  assign adv_tag   = rk;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (init_cnt == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load = 1'b1;
          priority if (sts.in_cell) begin
            state_next = S_CELL;
          end else if (sts.in_clear) begin
            state_next = S_CLR;
          end else if (sts.in_advance) begin
            state_next = S_ADV;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_CELL: begin
        cmd.cell_rd = 1'b1;
        state_next  = S_CELL_WB;
      end
      S_CELL_WB: begin
        cmd.cell_wb = 1'b1;
        state_next  = S_FIN;
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (cnt == CW'(MAX_ROWS - 1)) begin
          state_next = S_FIN;
        end
      end
      S_ADV: begin
        cmd.adv_rd = 1'b1;
        cmd.adv_wr = adv_v;
        if (cnt == CW'(MAX_ROWS)) begin
          state_next = S_ADV_END;
        end
      end
      S_ADV_END: begin
        cmd.adv_wr = 1'b1;
        cmd.flip   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.can_push) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_INIT;
      init_cnt <= '0;
      cnt      <= '0;
      adv_v    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_INIT) begin
        init_cnt <= init_cnt + 1'b1;
      end
      if (cmd.load) begin
        cnt   <= '0;
        adv_v <= 1'b0;
      end else if ((state == S_CLR) || (state == S_ADV)) begin
        cnt <= cnt + 1'b1;
      end
      if (state == S_ADV) begin
        adv_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ADV) begin
      rk <= cnt;
    end
  end

  `ASSERT_RST(a_tag_trails_count, clk, rst, (state == S_ADV && adv_v) |-> (int'(rk) + 1 == int'(cnt)), "row tag out of step with read count")
  `ASSERT_RST(a_accept_leaves_idle, clk, rst, (s_tvalid && s_tready) |=> (state != S_IDLE), "accepted transaction left the controller idle")
  `ASSERT_RST(a_fin_waits, clk, rst, (state == S_FIN && !sts.can_push) |=> (state == S_FIN), "result dropped while output register was full")
  `ASSERT_ALWAYS(a_reset_init, clk, rst |=> (state == S_INIT), "reset did not start the clearing pass")

endmodule

// File: hdl/life_generation_engine.sv
// Top level of the Life generation engine: controller and datapath.
//
// Channel   Direction  Handshake            Payload
// s_*       in         s_tvalid / s_tready  action, row, col, value
// m_*       out        m_tvalid / m_tready  cell_value
// cfg_*     in         cfg_we               rows_in_use, cols_in_use
//
// Write, toggle and read pass through S_CELL, S_CELL_WB and S_FIN after acceptance.
// Clear and advance step through the grid rows one row a cycle.
// After reset a clearing pass over all 2 * 2**clog2(MAX_ROWS) memory words holds s_tready low.
// A stalled output only holds the next item in its final state, S_FIN.
module life_generation_engine import lge_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // action[2:0], row[8:3], col[14:9], value[15]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // cell_value[0], zeros above
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int AW = RW + 1;
  localparam int CW = $clog2(MAX_ROWS + 1);

  cmd_t          cmd;
  sts_t          sts;
  logic [RW-1:0] cnt_row;
  logic [AW-1:0] init_addr;
  logic [CW-1:0] adv_tag;

  lge_controller #(
    .MAX_ROWS(MAX_ROWS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd),
    .cnt_row  (cnt_row),
    .init_addr(init_addr),
    .adv_tag  (adv_tag)
  );

  lge_datapath #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .cnt_row  (cnt_row),
    .init_addr(init_addr),
    .adv_tag  (adv_tag),
    .sts      (sts)
  );

endmodule
